// ===== sv/four_neighbor_glitch_filter_defines.svh =====
`ifndef FOUR_NEIGHBOR_GLITCH_FILTER_DEFINES_SVH
`define FOUR_NEIGHBOR_GLITCH_FILTER_DEFINES_SVH

// checks sampled on clk_i and held off while rst_ni is low
`define FNGF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define FNGF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fngf_pkg.sv =====
package fngf_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 63;
  localparam int unsigned PIXEL_BITS_DEF = 8;

  localparam int unsigned WIDTH_BITS  = 6;
  localparam int unsigned HEIGHT_BITS = 10;
  localparam int unsigned THRESH_BITS = 8;

  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 6'd30;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 10'd20;
  localparam logic [THRESH_BITS-1:0] THRESH_RST = 8'd1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH      = 2'd0,
    REG_FRAME_HEIGHT     = 2'd1,
    REG_GLITCH_THRESHOLD = 2'd2
  } reg_idx_e;

  // per-transaction classification made by the front end
  typedef struct packed {
    logic has_res;
    logic up;
    logic frame_end;
  } item_ctl_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  eff_width;
    logic [THRESH_BITS-1:0] thresh;
  } filt_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT
  } back_state_e;

endpackage

// ===== sv/fngf_if.sv =====
interface fngf_in_if #(
  parameter int unsigned PIXEL_BITS = fngf_pkg::PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface fngf_out_if #(
  parameter int unsigned PIXEL_BITS = fngf_pkg::PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  frame_done;
  logic                  run_last;

  modport source (output valid, output pixel_out, output frame_done, output run_last,
                  input ready);
  modport sink (input valid, input pixel_out, input frame_done, input run_last,
                output ready);
endinterface

// ===== sv/fngf_fifo.sv =====
module fngf_fifo #(
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/fngf_front.sv =====
module fngf_front #(
  parameter int unsigned MAX_WIDTH  = fngf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = fngf_pkg::PIXEL_BITS_DEF,
  localparam int unsigned CW        = $clog2(MAX_WIDTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fngf_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [fngf_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [fngf_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  fngf_in_if.sink                             in_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output logic [PIXEL_BITS-1:0]               pix_o,
  output logic [CW-1:0]                       col_o,
  output fngf_pkg::item_ctl_t                 ctl_o,
  output fngf_pkg::filt_cfg_t                 cfg_o
);

  import fngf_pkg::*;

  localparam logic [WIDTH_BITS-1:0] MAXW = WIDTH_BITS'(MAX_WIDTH);

  logic [WIDTH_BITS-1:0]  width_q;
  logic [HEIGHT_BITS-1:0] height_q;
  logic [THRESH_BITS-1:0] thresh_q;
  logic [CW-1:0]          col_q, col_d;
  logic [HEIGHT_BITS-1:0] row_q, row_d;

  logic [WIDTH_BITS-1:0]  eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic                   last_col, last_row;
  logic                   cfg_wr, accept;
  reg_idx_e               reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_BITS-1:2]);

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & ~q_full_i;

  // clamp width to between 2 and what the line stores can hold, height to at least 2
  always_comb begin
    if (width_q < WIDTH_BITS'(2)) begin
      eff_w = WIDTH_BITS'(2);
    end else if (width_q > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < HEIGHT_BITS'(2)) ? HEIGHT_BITS'(2) : height_q;
  end

  assign last_col = ((WIDTH_BITS + 1)'(col_q) + 1'b1) == {1'b0, eff_w};
  assign last_row = ({1'b0, row_q} + 1'b1) == {1'b0, eff_h};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + HEIGHT_BITS'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thresh_q <= THRESH_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_wr) begin
      // a geometry write restarts the frame
      unique case (reg_idx)
        REG_FRAME_WIDTH: begin
          width_q <= pwdata[WIDTH_BITS-1:0];
          col_q   <= '0;
          row_q   <= '0;
        end
        REG_FRAME_HEIGHT: begin
          height_q <= pwdata[HEIGHT_BITS-1:0];
          col_q    <= '0;
          row_q    <= '0;
        end
        REG_GLITCH_THRESHOLD: begin
          thresh_q <= pwdata[THRESH_BITS-1:0];
        end
        default: begin
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:      prdata = APB_DATA_BITS'(width_q);
      REG_FRAME_HEIGHT:     prdata = APB_DATA_BITS'(height_q);
      REG_GLITCH_THRESHOLD: prdata = APB_DATA_BITS'(thresh_q);
      default:              prdata = '0;
    endcase
  end

  assign push_o          = accept;
  assign pix_o           = in_i.pixel_in;
  assign col_o           = col_q;
  assign ctl_o.has_res   = (row_q != '0);
  assign ctl_o.up        = (row_q > HEIGHT_BITS'(1));
  assign ctl_o.frame_end = last_col & last_row;
  assign cfg_o.eff_width = eff_w;
  assign cfg_o.thresh    = thresh_q;

endmodule

// ===== sv/fngf_back.sv =====
`include "four_neighbor_glitch_filter_defines.svh"

module fngf_back #(
  parameter int unsigned MAX_WIDTH  = fngf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = fngf_pkg::PIXEL_BITS_DEF,
  localparam int unsigned CW        = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  output logic                  pop_o,
  input  logic [PIXEL_BITS-1:0] pix_i,
  input  logic [CW-1:0]         col_i,
  input  fngf_pkg::item_ctl_t   ctl_i,
  input  fngf_pkg::filt_cfg_t   cfg_i,
  fngf_out_if.source            out_o
);

  import fngf_pkg::*;

  localparam int unsigned SW   = PIXEL_BITS + 2;
  localparam int unsigned CMPW = (PIXEL_BITS > THRESH_BITS) ? PIXEL_BITS : THRESH_BITS;
  localparam logic [SW-1:0] RECIP3 = SW'((1 << SW) / 3);

  function automatic logic far(input logic [PIXEL_BITS-1:0]  a,
                               input logic [PIXEL_BITS-1:0]  b,
                               input logic [THRESH_BITS-1:0] t);
    logic [PIXEL_BITS-1:0] d;
    d = (a > b) ? a - b : b - a;
    return CMPW'(d) > CMPW'(t);
  endfunction

  // raw row r-1 ahead of the column, raw row r behind it
  logic [PIXEL_BITS-1:0] raw_mem [MAX_WIDTH];
  // filtered row r-2 ahead of the column, filtered row r-1 behind it
  logic [PIXEL_BITS-1:0] filt_mem [MAX_WIDTH];

  back_state_e           state_q, state_d;
  logic                  flush_q;
  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [CW-1:0]         col_q;
  item_ctl_t             ctl_q;
  logic [PIXEL_BITS-1:0] left_q;
  logic [PIXEL_BITS-1:0] rd_c_q, rd_r_q, rd_a_q;
  logic [PIXEL_BITS-1:0] center_q;
  logic [SW-1:0]         sum_q;
  logic [2:0]            k_q;
  logic                  glitch_q;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_done_q, out_last_q;

  logic [WIDTH_BITS:0]   col_wide, eff_wide;
  logic                  last_now;
  logic [CW-1:0]         right_addr;
  logic                  has_left, has_right, has_up, has_down;
  logic                  glitch;
  logic [SW-1:0]         sum;
  logic [2:0]            kcnt;
  logic [SW-1:0]         x, q0, q3, rem, avg;
  logic [2*SW-1:0]       prod;
  logic [PIXEL_BITS-1:0] result;
  logic                  out_free, emit, advance;
  logic                  raw_we;
  logic [CW-1:0]         raw_waddr;
  logic [PIXEL_BITS-1:0] raw_wdata;

  assign col_wide   = (WIDTH_BITS + 1)'(col_q);
  assign eff_wide   = {1'b0, cfg_i.eff_width};
  assign last_now   = (col_wide + 1'b1) == eff_wide;
  assign right_addr = last_now ? col_q : col_q + CW'(1);

  // neighbor set: flush rows have no row below
  assign has_left  = (col_q != '0);
  assign has_right = ~last_now;
  assign has_up    = flush_q | ctl_q.up;
  assign has_down  = ~flush_q;

  assign glitch = (~has_left  | far(rd_c_q, left_q, cfg_i.thresh)) &
                  (~has_right | far(rd_c_q, rd_r_q, cfg_i.thresh)) &
                  (~has_up    | far(rd_c_q, rd_a_q, cfg_i.thresh)) &
                  (~has_down  | far(rd_c_q, pix_q, cfg_i.thresh));

  assign sum = (has_left  ? SW'(left_q) : '0) + (has_right ? SW'(rd_r_q) : '0) +
               (has_up    ? SW'(rd_a_q) : '0) + (has_down  ? SW'(pix_q)  : '0);
  assign kcnt = 3'(has_left) + 3'(has_right) + 3'(has_up) + 3'(has_down);

  // rounded average, divide by three through a reciprocal and one correction
  assign x    = sum_q + ((k_q == 3'd4) ? SW'(2) : SW'(1));
  assign prod = (2 * SW)'(x) * (2 * SW)'(RECIP3);
  assign q0   = prod[2*SW-1:SW];
  assign rem  = x - ((q0 << 1) + q0);
  assign q3   = (rem >= SW'(3)) ? q0 + SW'(1) : q0;

  always_comb begin
    unique case (k_q)
      3'd3:    avg = q3;
      3'd4:    avg = x >> 2;
      default: avg = x >> 1;
    endcase
  end

  assign result   = glitch_q ? avg[PIXEL_BITS-1:0] : center_q;
  assign out_free = ~out_valid_q | out_o.ready;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (ctl_i.has_res) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (flush_q) begin
            state_d = last_now ? ST_IDLE : ST_READ;
          end else begin
            state_d = ctl_q.frame_end ? ST_READ : ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // move to the next flush column, or into the flush of the last row
  assign advance = emit & (flush_q ? ~last_now : ctl_q.frame_end);

  always_comb begin
    raw_we    = 1'b0;
    raw_waddr = col_q;
    raw_wdata = pix_q;
    if (pop_o && !ctl_i.has_res) begin
      raw_we    = 1'b1;
      raw_waddr = col_i;
      raw_wdata = pix_i;
    end else if (emit && !flush_q) begin
      raw_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        flush_q <= flush_q ? ~last_now : ctl_q.frame_end;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pix_q <= pix_i;
      col_q <= col_i;
      ctl_q <= ctl_i;
    end else if (advance) begin
      col_q <= flush_q ? col_q + CW'(1) : '0;
    end
    if (state_q == ST_CALC) begin
      center_q <= rd_c_q;
      sum_q    <= sum;
      k_q      <= kcnt;
      glitch_q <= glitch;
    end
    if (emit) begin
      left_q     <= result;
      out_pix_q  <= result;
      out_done_q <= flush_q & last_now;
      out_last_q <= flush_q ? last_now : ~ctl_q.frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_we) begin
      raw_mem[raw_waddr] <= raw_wdata;
    end
    if (emit) begin
      filt_mem[col_q] <= result;
    end
    if (state_q == ST_READ) begin
      rd_c_q <= raw_mem[col_q];
      rd_r_q <= raw_mem[right_addr];
      rd_a_q <= filt_mem[col_q];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_out  = out_pix_q;
  assign out_o.frame_done = out_done_q;
  assign out_o.run_last   = out_last_q;

  `FNGF_ASSERT_NOW(a_flush_col_in_frame, flush_q, col_wide < eff_wide, "flush column past width")
  `FNGF_ASSERT_NOW(a_done_is_last, out_o.valid && out_o.frame_done, out_o.run_last, "frame end not last")
  `FNGF_ASSERT_NOW(a_no_result_row0, emit && !flush_q, ctl_q.has_res, "result from first row")
  `FNGF_ASSERT_NEXT(a_flush_continues, emit && flush_q && !last_now, (state_q == ST_READ) && flush_q, "flush stopped early")

endmodule

// ===== sv/four_neighbor_glitch_filter.sv =====
// Four-neighbor glitch filter for a raster-order pixel stream.
// in_i takes raw pixels, out_o gives filtered pixels in raster order; both are
// valid/ready channels. Registers (APB, byte addresses 0, 4, 8): frame width,
// frame height and glitch threshold; a geometry write restarts the frame.
// Output lags input by one row: row 0 transactions give no result, each later
// transaction gives the filtered pixel one row above it, and the last pixel of
// the frame also releases the whole last row, ending with frame_done.
// Sequencing: a first-row pixel needs only the queue pop of the back-end sequencer;
// any other pixel goes through queue pop, line store read, compare/sum and average,
// and each pixel of the last-row flush goes through all of these but the pop. The
// back end finishes one pixel before it pops the next. The line stores have one
// write port, so every result reads its column and then writes it back.
// A two-entry queue between front and back lets input keep flowing while a
// result waits; a stalled receiver holds the output register and, once the
// queue fills, in_i.ready drops. Reset restores the default geometry and
// counters; line stores are not cleared and are written before being read.
module four_neighbor_glitch_filter #(
  parameter int unsigned MAX_WIDTH  = fngf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = fngf_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fngf_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [fngf_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [fngf_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  fngf_in_if.sink                            in_i,
  fngf_out_if.source                         out_o
);

  import fngf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned DW = PIXEL_BITS + CW + $bits(item_ctl_t);

  logic                  q_full, q_empty, push, pop;
  logic [PIXEL_BITS-1:0] f_pix, b_pix;
  logic [CW-1:0]         f_col, b_col;
  item_ctl_t             f_ctl, b_ctl;
  filt_cfg_t             cfg;
  logic [DW-1:0]         q_din, q_dout;

  fngf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .pix_o    (f_pix),
    .col_o    (f_col),
    .ctl_o    (f_ctl),
    .cfg_o    (cfg)
  );

  assign q_din = {f_pix, f_col, f_ctl};

  fngf_fifo #(
    .DW (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (q_dout),
    .empty_o (q_empty)
  );

  assign {b_pix, b_col, b_ctl} = q_dout;

  fngf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .pix_i     (b_pix),
    .col_i     (b_col),
    .ctl_i     (b_ctl),
    .cfg_i     (cfg),
    .out_o     (out_o)
  );

endmodule

// ===== bench/fngf_stream_check.sv =====
`timescale 1ns / 100ps

module fngf_stream_check (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [fngf_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [fngf_pkg::APB_DATA_BITS-1:0] pwdata,
  fngf_in_if                                 in_mon_i,
  fngf_out_if                                out_mon_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  import fngf_pkg::*;

  localparam int LINE_LEN = MAX_WIDTH_DEF;

  typedef struct packed {
    logic [PIXEL_BITS_DEF-1:0] pixel;
    logic                      frame_done;
    logic                      run_last;
  } filtered_px_t;

  logic [WIDTH_BITS-1:0]     frame_w;
  logic [HEIGHT_BITS-1:0]    frame_h;
  logic [THRESH_BITS-1:0]    thresh;
  logic [PIXEL_BITS_DEF-1:0] line_above [LINE_LEN];
  logic [PIXEL_BITS_DEF-1:0] line_mid   [LINE_LEN];
  logic [PIXEL_BITS_DEF-1:0] line_new   [LINE_LEN];
  int                        col_pos;
  int                        row_pos;
  filtered_px_t              filtered_q [$];
  int                        fail_cnt;

  function automatic bit exceeds_threshold(logic [PIXEL_BITS_DEF-1:0] a,
                                           logic [PIXEL_BITS_DEF-1:0] b);
    int diff;
    diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return diff > int'(thresh);
  endfunction

  // left and above are already corrected, right and below still raw
  function automatic logic [PIXEL_BITS_DEF-1:0] filter_column(int col, int w, bit up,
                                                              bit down);
    logic [PIXEL_BITS_DEF-1:0] p;
    int sum;
    int k;
    bit glitch;
    p = line_mid[col];
    sum = 0;
    k = 0;
    glitch = 1'b1;
    if (col > 0) begin
      sum += line_mid[col-1];
      k++;
      if (!exceeds_threshold(p, line_mid[col-1])) glitch = 1'b0;
    end
    if (col + 1 < w) begin
      sum += line_mid[col+1];
      k++;
      if (!exceeds_threshold(p, line_mid[col+1])) glitch = 1'b0;
    end
    if (up) begin
      sum += line_above[col];
      k++;
      if (!exceeds_threshold(p, line_above[col])) glitch = 1'b0;
    end
    if (down) begin
      sum += line_new[col];
      k++;
      if (!exceeds_threshold(p, line_new[col])) glitch = 1'b0;
    end
    // average rounded to nearest, halves up
    if (glitch && k > 0) p = PIXEL_BITS_DEF'((sum + k / 2) / k);
    line_mid[col] = p;
    return p;
  endfunction

  task automatic predict_pixel(input logic [PIXEL_BITS_DEF-1:0] px);
    int w;
    int h;
    int c;
    int r;
    int total;
    int idx;
    bit row_end;
    bit frame_end;
    logic [PIXEL_BITS_DEF-1:0] v;
    w = (frame_w < 2) ? 2 : int'(frame_w);
    h = (frame_h < 2) ? 2 : int'(frame_h);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    line_new[c] = px;
    row_end = (c + 1 == w);
    frame_end = row_end && (r + 1 == h);
    total = (r >= 1 ? 1 : 0) + (frame_end ? w : 0);
    idx = 0;
    if (r >= 1) begin
      v = filter_column(c, w, r >= 2, 1'b1);
      filtered_q.push_back('{pixel: v, frame_done: 1'b0, run_last: idx + 1 == total});
      idx++;
    end
    if (row_end) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        line_above[i] = line_mid[i];
        line_mid[i] = line_new[i];
      end
      c = 0;
      r++;
    end else begin
      c++;
    end
    // last pixel of the frame releases the whole bottom row
    if (frame_end) begin
      for (int col = 0; col < w; col++) begin
        v = filter_column(col, w, 1'b1, 1'b0);
        filtered_q.push_back('{pixel: v, frame_done: col + 1 == w,
                               run_last: idx + 1 == total});
        idx++;
      end
      r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    filtered_px_t want;
    if (!rst_ni) begin
      frame_w = WIDTH_RST;
      frame_h = HEIGHT_RST;
      thresh = THRESH_RST;
      col_pos = 0;
      row_pos = 0;
      filtered_q.delete();
      fail_cnt = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (filtered_q.size() == 0) begin
          $error("pixel_out: no result expected, got %0d", out_mon_i.pixel_out);
          fail_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (out_mon_i.pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, out_mon_i.pixel_out);
            fail_cnt++;
          end
          if (out_mon_i.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done,
                   out_mon_i.frame_done);
            fail_cnt++;
          end
          if (out_mon_i.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_mon_i.run_last);
            fail_cnt++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) predict_pixel(in_mon_i.pixel_in);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FRAME_WIDTH: begin
            frame_w = pwdata[WIDTH_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_FRAME_HEIGHT: begin
            frame_h = pwdata[HEIGHT_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_GLITCH_THRESHOLD: thresh = pwdata[THRESH_BITS-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fail_cnt;
    pending_o <= filtered_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import fngf_pkg::*;

  localparam int unsigned REG_SPARE     = 3;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          RANDOM_PIXELS = 300;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int fail_count;
  int pending;
  int quiet_cycles;
  int pixels_sent;
  bit tx_gaps;
  bit rx_gaps;

  fngf_in_if  in_ch ();
  fngf_out_if out_ch ();

  four_neighbor_glitch_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  fngf_stream_check result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall before each transaction when gaps are enabled
  initial begin : pixel_sink
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic write_reg(input int unsigned idx, input int unsigned value,
                           input int unsigned bits);
    logic [APB_DATA_BITS-1:0] field_mask;
    field_mask = (32'd1 << bits) - 32'd1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'(idx * 4);
    // junk above the field must be dropped
    pwdata <= ($urandom() & ~field_mask) | (value & field_mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIXEL_BITS_DEF-1:0] px);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_in <= px;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // first-row pixels give no result, so allow the block to finish them too
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned th);
    settle();
    write_reg(REG_FRAME_WIDTH, w, WIDTH_BITS);
    write_reg(REG_FRAME_HEIGHT, h, HEIGHT_BITS);
    write_reg(REG_GLITCH_THRESHOLD, th, THRESH_BITS);
  endtask

  initial begin : stimulus
    int w_reg;
    int h_reg;
    int th;
    int w_eff;
    int h_eff;
    int count;
    int base;
    int pause_at;
    int phase_no;
    int v;
    bit noisy;
    in_ch.valid <= 1'b0;
    in_ch.pixel_in <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // undersized geometry acts as 2x2, threshold too high for any glitch
    set_geometry(1, 0, 255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    // zero threshold: the top-left corner is a glitch whose half-way average rounds up
    settle();
    write_reg(REG_GLITCH_THRESHOLD, 0, THRESH_BITS);
    send_pixel(8'd200);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd0);
    // lone spike in the middle of a flat 3x3 frame
    set_geometry(3, 3, 10);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd255 : 8'd0);
    // partial frame cut short by a geometry write below
    for (int i = 0; i < 3; i++) send_pixel(8'd7);
    settle();
    write_reg(REG_SPARE, $urandom(), THRESH_BITS);

    pixels_sent = 0;
    phase_no = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 7))
        0: th = 0;
        1: th = 255;
        default: th = $urandom_range(1, 24);
      endcase
      if (phase_no == 0) begin
        w_reg = 63;
        h_reg = 2;
      end else if (phase_no == 1) begin
        w_reg = $urandom_range(2, 5);
        h_reg = 1023;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            w_reg = $urandom_range(0, 1);
            h_reg = $urandom_range(2, 5);
          end
          1: begin
            w_reg = $urandom_range(2, 8);
            h_reg = $urandom_range(0, 1);
          end
          default: begin
            w_reg = $urandom_range(2, 8);
            h_reg = $urandom_range(2, 5);
          end
        endcase
      end
      set_geometry(w_reg, h_reg, th);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom(), THRESH_BITS);
      w_eff = (w_reg < 2) ? 2 : w_reg;
      h_eff = (h_reg < 2) ? 2 : h_reg;
      if (phase_no == 1) count = $urandom_range(2 * w_eff, 4 * w_eff);
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(1, w_eff * h_eff - 1);
      else count = w_eff * h_eff * $urandom_range(1, 2);
      if (count > RANDOM_PIXELS - pixels_sent) count = RANDOM_PIXELS - pixels_sent;
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      noisy = ($urandom_range(0, 3) == 0);
      pause_at = ($urandom_range(0, 1) == 1) ? $urandom_range(0, count - 1) : -1;
      base = $urandom_range(0, 255);
      for (int i = 0; i < count; i++) begin
        if (i == pause_at) hold_until_drained();
        if (noisy || $urandom_range(0, 3) == 0) begin
          v = $urandom_range(0, 255);
        end else begin
          // flat background with slight noise, spikes stand out
          v = base + $urandom_range(0, 6) - 3;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        send_pixel(PIXEL_BITS_DEF'(v));
      end
      pixels_sent += count;
      phase_no++;
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
